@@ hdl/assert_macros.svh @@
// assertion helpers, clocked on clk with reset held off through rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PFDE_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PFDE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/pfde_pkg.sv @@
`timescale 1ns / 1ps

package pfde_pkg;

    localparam int COORD_W    = 11;
    localparam int IN_DATA_W  = 56;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 8;

    typedef enum logic [2:0] {
        CMD_PIXEL      = 3'd0,
        CMD_FILL       = 3'd1,
        CMD_BLIT_BEGIN = 3'd2,
        CMD_BLIT_BYTE  = 3'd3,
        CMD_CLEAR      = 3'd4,
        CMD_READ       = 3'd5
    } cmd_t;

    typedef struct packed {
        logic accept;
        logic pix_rd;
        logic pix_wr;
        logic clr_wr;
        logic rd_issue;
        logic load_out;
    } ctrl_t;

    typedef struct packed {
        logic new_rect_empty;
        logic blit_active;
        logic pix_last;
        logic clr_last;
    } stat_t;

endpackage

@@ hdl/page_framebuffer_draw_engine.sv @@
// pixel, fill rect and bitmap byte do a read and a write per pixel drawn, none for an empty rect
// or idle bitmap; clear zeros the store; read, begin and others go straight to the result
// one item at a time; each pixel is a read-modify-write on the frame store
// the next item can be taken the cycle after a result is loaded into the output register,
// and a result is loaded only once the output register is empty or m_tready is high
// after reset a clearing pass zeros all width * ceil(height/8) bytes of the store, s_tready low
`timescale 1ns / 1ps
`include "assert_macros.svh"

module page_framebuffer_draw_engine #(
    parameter int SCREEN_WIDTH  = 102,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // x_pos[8:0], y_pos[17:9], rect_width[25:18], rect_height[33:26], pixel_on[34],
    // bitmap_bits[42:35], store_index[52:43], zero[55:53]
    input  logic [pfde_pkg::IN_DATA_W-1:0]   s_tdata,
    // command[2:0]
    input  logic [pfde_pkg::IN_USER_W-1:0]   s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // read_data[7:0]
    output logic [pfde_pkg::OUT_DATA_W-1:0]  m_tdata,
    // bitmap_done
    output logic                             m_tlast,
    // status[0]
    output logic                             m_tuser
);
    import pfde_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    pfde_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    pfde_dp #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .ctrl    (ctrl),
        .stat    (stat),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    `PFDE_ASSERT_IMPLY(a_accept_no_write, ctrl.accept, !ctrl.pix_wr && !ctrl.clr_wr, "write on accept")
    `PFDE_ASSERT_NEXT(a_rd_then_wr, ctrl.pix_rd, ctrl.pix_wr, "pixel read not followed by write")
    `PFDE_ASSERT_IMPLY(a_load_slot_free, ctrl.load_out, !m_tvalid || m_tready, "result overwritten")
    `PFDE_ASSERT_IMPLY(a_ready_quiet, s_tready, !ctrl.pix_rd && !ctrl.clr_wr, "store busy while ready")

endmodule

@@ hdl/pfde_ctrl.sv @@
`timescale 1ns / 1ps

module pfde_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [pfde_pkg::IN_USER_W-1:0]   s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  pfde_pkg::stat_t                  stat,
    output pfde_pkg::ctrl_t                  ctrl
);
    import pfde_pkg::*;

    typedef enum logic [5:0] {
        ST_INIT   = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_PIX_RD = 6'b000100,
        ST_PIX_WR = 6'b001000,
        ST_CLEAR  = 6'b010000,
        ST_RESP   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    cmd_t   cmd_in;

    assign cmd_in   = cmd_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        ctrl           = '0;
        unique case (state_reg)
            ST_INIT:
            begin
                ctrl.clr_wr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    ctrl.accept = 1'b1;
                    unique case (cmd_in)
                        CMD_PIXEL:
                        begin
                            state_next = ST_PIX_RD;
                        end
                        CMD_FILL:
                        begin
                            state_next = stat.new_rect_empty ? ST_RESP : ST_PIX_RD;
                        end
                        CMD_BLIT_BYTE:
                        begin
                            state_next = stat.blit_active ? ST_PIX_RD : ST_RESP;
                        end
                        CMD_CLEAR:
                        begin
                            state_next = ST_CLEAR;
                        end
                        CMD_READ:
                        begin
                            ctrl.rd_issue = 1'b1;
                            state_next    = ST_RESP;
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_PIX_RD:
            begin
                ctrl.pix_rd = 1'b1;
                state_next  = ST_PIX_WR;
            end
            ST_PIX_WR:
            begin
                ctrl.pix_wr = 1'b1;
                state_next  = stat.pix_last ? ST_RESP : ST_PIX_RD;
            end
            ST_CLEAR:
            begin
                ctrl.clr_wr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    ctrl.load_out  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ hdl/pfde_dp.sv @@
`timescale 1ns / 1ps

module pfde_dp #(
    parameter int SCREEN_WIDTH  = 102,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [pfde_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic [pfde_pkg::IN_USER_W-1:0]   s_tuser,
    input  pfde_pkg::ctrl_t                  ctrl,
    output pfde_pkg::stat_t                  stat,
    output logic [pfde_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                             m_tlast,
    output logic                             m_tuser
);
    import pfde_pkg::*;

    localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
    localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
    localparam int ADDR_W      = $clog2(STORE_BYTES);

    // input unpacking
    logic [2:0]        in_cmd;
    logic signed [8:0] in_x;
    logic signed [8:0] in_y;
    logic [7:0]        in_w;
    logic [7:0]        in_h;
    logic              in_on;
    logic [7:0]        in_bits;
    logic [9:0]        in_idx;
    logic              in_idx_ok;

    assign in_cmd    = s_tuser;
    assign in_x      = signed'(s_tdata[8:0]);
    assign in_y      = signed'(s_tdata[17:9]);
    assign in_w      = s_tdata[25:18];
    assign in_h      = s_tdata[33:26];
    assign in_on     = s_tdata[34];
    assign in_bits   = s_tdata[42:35];
    assign in_idx    = s_tdata[52:43];
    assign in_idx_ok = int'(in_idx) < STORE_BYTES;

    // latched command
    logic [2:0]        cmd_reg;
    logic signed [8:0] x_reg;
    logic signed [8:0] y_reg;
    logic [7:0]        w_reg;
    logic [7:0]        h_reg;
    logic              on_reg;
    logic [7:0]        bits_reg;
    logic              idx_ok_reg;

    // loop counters
    logic [7:0]        i_reg;
    logic [7:0]        j_reg;
    logic [2:0]        k_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    // bitmap state
    logic signed [8:0] ox_reg;
    logic signed [8:0] oy_reg;
    logic [7:0]        bw_reg;
    logic [7:0]        bh_reg;
    logic [7:0]        col_reg;
    logic [7:0]        row_reg;
    logic              active_reg;

    logic              done_reg;
    logic              status_reg;
    logic [7:0]        rdata_reg;
    logic [7:0]        out_data_reg;
    logic              out_last_reg;
    logic              out_user_reg;

    // pixel address path
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] prow;
    logic                      pix_ok;
    logic                      pix_on;
    logic [ADDR_W-1:0]         pix_addr;
    logic [7:0]                pix_mask;
    logic                      col_wrap;
    logic                      row_end;
    logic                      pix_last;

    always_comb
    begin
        unique case (cmd_reg)
            CMD_FILL:
            begin
                px     = COORD_W'(x_reg) + signed'(COORD_W'(i_reg));
                py     = COORD_W'(y_reg) + signed'(COORD_W'(j_reg));
                pix_on = 1'b1;
            end
            CMD_BLIT_BYTE:
            begin
                px     = COORD_W'(ox_reg) + signed'(COORD_W'(col_reg));
                py     = COORD_W'(oy_reg) + signed'(COORD_W'(row_reg));
                pix_on = bits_reg[k_reg];
            end
            default:
            begin
                px     = COORD_W'(x_reg);
                py     = COORD_W'(y_reg);
                pix_on = on_reg;
            end
        endcase
    end

    assign pix_ok   = (px >= 0) && (px < signed'(COORD_W'(SCREEN_WIDTH)))
                      && (py >= 0) && (py < signed'(COORD_W'(SCREEN_HEIGHT)));
    assign prow     = signed'(COORD_W'(SCREEN_HEIGHT - 1)) - py;
    assign pix_addr = ADDR_W'(int'(prow[COORD_W-1:3]) * SCREEN_WIDTH + int'(px));
    assign pix_mask = 8'(1) << prow[2:0];

    assign col_wrap = ({1'b0, col_reg} + 9'd1) >= {1'b0, bw_reg};
    assign row_end  = ({1'b0, row_reg} + 9'd1) >= {1'b0, bh_reg};

    always_comb
    begin
        unique case (cmd_reg)
            CMD_FILL:
            begin
                pix_last = (i_reg == w_reg - 8'd1) && (j_reg == h_reg - 8'd1);
            end
            CMD_BLIT_BYTE:
            begin
                pix_last = (k_reg == 3'd7) || (col_wrap && row_end);
            end
            default:
            begin
                pix_last = 1'b1;
            end
        endcase
    end

    assign stat.pix_last       = pix_last;
    assign stat.new_rect_empty = (in_w == 8'd0) || (in_h == 8'd0);
    assign stat.blit_active    = active_reg;
    assign stat.clr_last       = clr_addr_reg == ADDR_W'(STORE_BYTES - 1);

    // frame store
    logic [7:0]        mem [STORE_BYTES];
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        wr_data;

    assign mem_we  = (ctrl.pix_wr && pix_ok) || ctrl.clr_wr;
    assign wr_addr = ctrl.clr_wr ? clr_addr_reg : pix_addr;
    assign wr_data = ctrl.clr_wr ? 8'd0
                   : (pix_on ? (rdata_reg | pix_mask) : (rdata_reg & ~pix_mask));
    assign mem_re  = (ctrl.pix_rd && pix_ok) || (ctrl.rd_issue && in_idx_ok);
    assign rd_addr = ctrl.rd_issue ? ADDR_W'(in_idx) : pix_addr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // command payload
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            x_reg      <= in_x;
            y_reg      <= in_y;
            w_reg      <= in_w;
            h_reg      <= in_h;
            on_reg     <= in_on;
            bits_reg   <= in_bits;
            idx_ok_reg <= in_idx_ok;
        end
        if (ctrl.load_out)
        begin
            out_data_reg <= (cmd_reg == CMD_READ && idx_ok_reg) ? rdata_reg : 8'd0;
            out_last_reg <= done_reg;
            out_user_reg <= status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg      <= CMD_PIXEL;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            clr_addr_reg <= '0;
            ox_reg       <= '0;
            oy_reg       <= '0;
            bw_reg       <= '0;
            bh_reg       <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            active_reg   <= 1'b0;
            done_reg     <= 1'b0;
            status_reg   <= 1'b0;
        end
        else
        begin
            if (ctrl.accept)
            begin
                cmd_reg      <= in_cmd;
                i_reg        <= '0;
                j_reg        <= '0;
                k_reg        <= '0;
                clr_addr_reg <= '0;
                done_reg     <= 1'b0;
                status_reg   <= (in_cmd == CMD_BLIT_BYTE) && !active_reg;
                if (in_cmd == CMD_BLIT_BEGIN)
                begin
                    ox_reg     <= in_x;
                    oy_reg     <= in_y;
                    bw_reg     <= in_w;
                    bh_reg     <= in_h;
                    col_reg    <= '0;
                    row_reg    <= '0;
                    active_reg <= (in_w != 8'd0) && (in_h != 8'd0);
                end
            end
            if (ctrl.clr_wr)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            if (ctrl.pix_wr)
            begin
                if (cmd_reg == CMD_FILL)
                begin
                    if (j_reg == h_reg - 8'd1)
                    begin
                        j_reg <= '0;
                        i_reg <= i_reg + 8'd1;
                    end
                    else
                    begin
                        j_reg <= j_reg + 8'd1;
                    end
                end
                else if (cmd_reg == CMD_BLIT_BYTE)
                begin
                    k_reg <= k_reg + 3'd1;
                    if (col_wrap)
                    begin
                        col_reg <= '0;
                        row_reg <= row_reg + 8'd1;
                        if (row_end)
                        begin
                            active_reg <= 1'b0;
                            done_reg   <= 1'b1;
                        end
                    end
                    else
                    begin
                        col_reg <= col_reg + 8'd1;
                    end
                end
            end
        end
    end

    assign m_tdata = out_data_reg;
    assign m_tlast = out_last_reg;
    assign m_tuser = out_user_reg;

endmodule

@@ dv/page_framebuffer_draw_engine_tb.sv @@
`timescale 1ns / 1ps

module page_framebuffer_draw_engine_tb;

    import pfde_pkg::*;

    localparam int SCREEN_WIDTH  = 102;
    localparam int SCREEN_HEIGHT = 64;
    localparam int STORE_BYTES   = SCREEN_WIDTH * ((SCREEN_HEIGHT + 7) / 8);
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int TAIL_CYCLES   = 40;

    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    typedef struct {
        logic [2:0]        cmd;
        logic signed [8:0] x_pos;
        logic signed [8:0] y_pos;
        logic [7:0]        rect_width;
        logic [7:0]        rect_height;
        logic              pixel_on;
        logic [7:0]        bitmap_bits;
        logic [9:0]        store_index;
    } draw_cmd_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       bitmap_done;
        logic       status;
    } draw_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic [IN_USER_W-1:0]   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;

    // predicted frame store and bitmap cursor
    logic [7:0]   page_bytes [STORE_BYTES];
    int           bm_x0;
    int           bm_y0;
    int unsigned  bm_width;
    int unsigned  bm_height;
    int unsigned  bm_col;
    int unsigned  bm_row;
    bit           bm_live;

    draw_result_t expected_results [$];
    draw_result_t want_result;
    int           mismatch_count = 0;
    int           send_gap_pct;
    int           recv_gap_pct;
    int unsigned  cycle_count = 0;

    page_framebuffer_draw_engine #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("FAIL");
        $finish;
    end

    task automatic report_mismatch(string what);
        $display("%0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic void plot(int px, int py, bit on);
        int row;
        int addr;
        if (px < 0 || py < 0 || px >= SCREEN_WIDTH || py >= SCREEN_HEIGHT)
            return;
        row  = SCREEN_HEIGHT - 1 - py;
        addr = (row / 8) * SCREEN_WIDTH + px;
        page_bytes[10'(addr)][3'(row % 8)] = on;
    endfunction

    function automatic draw_result_t predict_draw(draw_cmd_t c);
        draw_result_t r;
        int i;
        int j;
        r = '0;
        case (c.cmd)
            CMD_PIXEL:
                plot(int'(c.x_pos), int'(c.y_pos), c.pixel_on);
            CMD_FILL:
                for (i = 0; i < int'(c.rect_width); i++)
                    for (j = 0; j < int'(c.rect_height); j++)
                        plot(int'(c.x_pos) + i, int'(c.y_pos) + j, 1'b1);
            CMD_BLIT_BEGIN:
            begin
                bm_x0     = int'(c.x_pos);
                bm_y0     = int'(c.y_pos);
                bm_width  = 32'(c.rect_width);
                bm_height = 32'(c.rect_height);
                bm_col    = 0;
                bm_row    = 0;
                bm_live   = (c.rect_width != 0) && (c.rect_height != 0);
            end
            CMD_BLIT_BYTE:
            begin
                if (!bm_live)
                    r.status = 1'b1;
                for (i = 0; i < 8 && bm_live; i++)
                begin
                    plot(bm_x0 + int'(bm_col), bm_y0 + int'(bm_row), c.bitmap_bits[i]);
                    bm_col++;
                    if (bm_col >= bm_width)
                    begin
                        bm_col = 0;
                        bm_row++;
                        if (bm_row >= bm_height)
                        begin
                            bm_live       = 1'b0;
                            r.bitmap_done = 1'b1;
                        end
                    end
                end
            end
            CMD_CLEAR:
                foreach (page_bytes[k])
                    page_bytes[k] = 8'h00;
            CMD_READ:
                if (c.store_index < STORE_BYTES)
                    r.read_data = page_bytes[c.store_index];
            default:
                ;
        endcase
        return r;
    endfunction

    function automatic int rnd_between(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // mostly around the visible area, sometimes anywhere in the 9-bit range
    function automatic int near_coord(int span);
        if ($urandom_range(99) < 85)
            return rnd_between(-6, span + 5);
        return rnd_between(-256, 255);
    endfunction

    function automatic draw_cmd_t random_cmd(logic [2:0] op);
        draw_cmd_t c;
        c.cmd         = op;
        c.x_pos       = 9'($urandom);
        c.y_pos       = 9'($urandom);
        c.rect_width  = 8'($urandom);
        c.rect_height = 8'($urandom);
        c.pixel_on    = 1'($urandom);
        c.bitmap_bits = 8'($urandom);
        c.store_index = ($urandom_range(9) == 0) ? 10'($urandom) :
                        10'($urandom_range(STORE_BYTES - 1));
        return c;
    endfunction

    function automatic void place_near(inout draw_cmd_t c);
        c.x_pos = 9'(near_coord(SCREEN_WIDTH));
        c.y_pos = 9'(near_coord(SCREEN_HEIGHT));
    endfunction

    function automatic draw_cmd_t cmd_of(logic [2:0] op, int x, int y, int w, int h,
                                         bit on, int pix_bits, int idx);
        draw_cmd_t c;
        c.cmd         = op;
        c.x_pos       = 9'(x);
        c.y_pos       = 9'(y);
        c.rect_width  = 8'(w);
        c.rect_height = 8'(h);
        c.pixel_on    = on;
        c.bitmap_bits = 8'(pix_bits);
        c.store_index = 10'(idx);
        return c;
    endfunction

    task automatic send_cmd(draw_cmd_t c);
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c.cmd;
        s_tdata  <= {3'b000, c.store_index, c.bitmap_bits, c.pixel_on,
                     c.rect_height, c.rect_width, c.y_pos, c.x_pos};
        do
            @(posedge clk);
        while (!s_tready);
        expected_results.push_back(predict_draw(c));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result transfer with nothing outstanding");
            else
            begin
                want_result = expected_results.pop_front();
                if (m_tdata !== want_result.read_data)
                    report_mismatch($sformatf("read_data got %h want %h",
                                              m_tdata, want_result.read_data));
                if (m_tlast !== want_result.bitmap_done)
                    report_mismatch($sformatf("bitmap_done got %b want %b",
                                              m_tlast, want_result.bitmap_done));
                if (m_tuser !== want_result.status)
                    report_mismatch($sformatf("status got %b want %b",
                                              m_tuser, want_result.status));
            end
        end
        m_tready <= ($urandom_range(99) >= recv_gap_pct);
    end

    task automatic test_pixel_clipping();
        send_cmd(cmd_of(CMD_PIXEL, 0, 0, 0, 0, 1'b1, 0, 0));
        send_cmd(cmd_of(CMD_PIXEL, 101, 0, 0, 0, 1'b1, 0, 0));
        send_cmd(cmd_of(CMD_PIXEL, -256, 255, 255, 255, 1'b1, 255, 1023));
        send_cmd(cmd_of(CMD_PIXEL, 255, -256, 0, 0, 1'b1, 0, 0));
        send_cmd(cmd_of(CMD_READ, 0, 0, 0, 0, 1'b0, 0, 714));
        send_cmd(cmd_of(CMD_PIXEL, 0, 0, 0, 0, 1'b0, 0, 0));
        send_cmd(cmd_of(CMD_READ, 0, 0, 0, 0, 1'b0, 0, 714));
        send_cmd(cmd_of(CMD_READ, 0, 0, 0, 0, 1'b0, 0, STORE_BYTES - 1));
        send_cmd(cmd_of(CMD_READ, 0, 0, 0, 0, 1'b0, 0, STORE_BYTES));
        send_cmd(cmd_of(CMD_READ, -1, -1, 255, 255, 1'b1, 255, 1023));
    endtask

    task automatic test_fill_rect();
        send_cmd(cmd_of(CMD_FILL, 10, 10, 0, 5, 1'b0, 0, 0));
        send_cmd(cmd_of(CMD_FILL, 10, 10, 5, 0, 1'b0, 0, 0));
        send_cmd(cmd_of(CMD_FILL, -3, -3, 6, 6, 1'b0, 0, 0));
        send_cmd(cmd_of(CMD_FILL, 0, 0, 255, 255, 1'b0, 0, 0));
        send_cmd(cmd_of(CMD_READ, 0, 0, 0, 0, 1'b0, 0, 0));
    endtask

    task automatic test_clear();
        send_cmd(cmd_of(CMD_CLEAR, 0, 0, 0, 0, 1'b0, 0, 0));
        send_cmd(cmd_of(CMD_READ, 0, 0, 0, 0, 1'b0, 0, 0));
    endtask

    task automatic test_bitmap_edges();
        send_cmd(cmd_of(CMD_BLIT_BYTE, 0, 0, 0, 0, 1'b0, 8'hff, 0));
        send_cmd(cmd_of(CMD_BLIT_BEGIN, 5, 5, 0, 3, 1'b0, 0, 0));
        send_cmd(cmd_of(CMD_BLIT_BYTE, 0, 0, 0, 0, 1'b0, 8'hff, 0));
        // partly off the left edge, ends mid byte
        send_cmd(cmd_of(CMD_BLIT_BEGIN, -1, 62, 3, 2, 1'b0, 0, 0));
        // clear keeps the bitmap going
        send_cmd(cmd_of(CMD_CLEAR, 0, 0, 0, 0, 1'b0, 0, 0));
        send_cmd(cmd_of(CMD_BLIT_BYTE, 0, 0, 0, 0, 1'b0, 8'hff, 0));
        // left unfinished, the next begin abandons it
        send_cmd(cmd_of(CMD_BLIT_BEGIN, 255, 255, 255, 255, 1'b1, 0, 0));
        send_cmd(cmd_of(CMD_BLIT_BYTE, 0, 0, 0, 0, 1'b0, 8'h55, 0));
    endtask

    task automatic test_unused_codes();
        send_cmd(random_cmd(CMD_SPARE_6));
        send_cmd(random_cmd(CMD_SPARE_7));
    endtask

    task automatic test_random_mix(int n);
        draw_cmd_t c;
        int        pick;
        int        k;
        for (k = 0; k < n; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 20)
            begin
                c = random_cmd(CMD_PIXEL);
                place_near(c);
            end
            else if (pick < 30)
            begin
                c = random_cmd(CMD_FILL);
                place_near(c);
                if ($urandom_range(49) == 0)
                begin
                    c.rect_width  = 8'($urandom_range(96));
                    c.rect_height = 8'($urandom_range(96));
                end
                else
                begin
                    c.rect_width  = 8'($urandom_range(16));
                    c.rect_height = 8'($urandom_range(16));
                end
            end
            else if (pick < 36)
            begin
                c = random_cmd(CMD_BLIT_BEGIN);
                place_near(c);
                if ($urandom_range(29) != 0)
                begin
                    c.rect_width  = 8'($urandom_range(20));
                    c.rect_height = 8'($urandom_range(12));
                end
            end
            else if (pick < 56)
                c = random_cmd(CMD_BLIT_BYTE);
            else if (pick < 58)
                c = random_cmd(CMD_CLEAR);
            else if (pick < 95)
                c = random_cmd(CMD_READ);
            else
                c = random_cmd($urandom_range(1) ? CMD_SPARE_6 : CMD_SPARE_7);
            send_cmd(c);
        end
    endtask

    task automatic test_bitmap_streams(int n);
        draw_cmd_t c;
        int        sent;
        int        byte_count;
        int        k;
        sent = 0;
        while (sent < n)
        begin
            c = random_cmd(CMD_BLIT_BEGIN);
            place_near(c);
            c.rect_width  = 8'($urandom_range(1, 24));
            c.rect_height = 8'($urandom_range(1, 12));
            byte_count = (int'(c.rect_width) * int'(c.rect_height) + 7) / 8;
            case ($urandom_range(9))
                0: byte_count = $urandom_range(byte_count - 1);
                1: byte_count = byte_count + 1;
                default: ;
            endcase
            send_cmd(c);
            sent++;
            for (k = 0; k < byte_count; k++)
            begin
                send_cmd(random_cmd(CMD_BLIT_BYTE));
                sent++;
                if ($urandom_range(7) == 0)
                begin
                    send_cmd(random_cmd(CMD_READ));
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        s_tvalid       <= 1'b0;
        s_tdata        <= '0;
        s_tuser        <= '0;
        bm_x0          = 0;
        bm_y0          = 0;
        bm_width       = 0;
        bm_height      = 0;
        bm_col         = 0;
        bm_row         = 0;
        bm_live        = 1'b0;
        foreach (page_bytes[k])
            page_bytes[k] = 8'h00;

        send_gap_pct = 17;
        recv_gap_pct = 71;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_pixel_clipping();
        test_fill_rect();
        test_clear();
        test_bitmap_edges();
        test_unused_codes();
        test_random_mix(85);
        test_bitmap_streams(50);
        wait_drained();

        send_gap_pct = 71;
        recv_gap_pct = 17;
        test_random_mix(85);
        test_bitmap_streams(50);
        wait_drained();

        send_gap_pct = 0;
        recv_gap_pct = 0;
        test_random_mix(85);
        test_bitmap_streams(50);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
